>>> hdl/tcjs_pkg.sv
// ----------------------------------------------------------------------------
// tcjs_pkg
// Shared types, codes and constants of the tick driven job scheduler.
// ----------------------------------------------------------------------------
package tcjs_pkg;

	localparam int MAX_JOBS_DEF  = 16;
	localparam int TIME_BITS_DEF = 32;

	localparam int ID_W    = 8;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int ARR_W   = 32;
	localparam int TICK_W  = 32;
	localparam int SUM_W   = 48;
	localparam int DONE_W  = 16;
	localparam int MODE_W  = 3;
	localparam int QUANT_W = 16;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 1;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CIDX_W-1:0] CFG_MODE    = 1'd0;
	localparam logic [CIDX_W-1:0] CFG_QUANTUM = 1'd1;

	localparam logic [MODE_W-1:0] MODE_FCFS    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SJF_NP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SJF_P   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PRIO_NP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PRIO_P  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RR      = 3'd5;

	typedef enum logic [1:0] {
		SLOT_EMPTY,
		SLOT_WAIT,
		SLOT_READY
	} slot_st_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADD_SCAN,
		ST_ADMIT,
		ST_PICK_INIT,
		ST_PICK_SCAN,
		ST_RUN,
		ST_WAIT_CALC,
		ST_FIX,
		ST_OUT
	} ctrl_st_t;

	typedef struct packed {
		logic latch;
		logic add_step;
		logic set_full;
		logic adm_step;
		logic adm_end;
		logic pick_clear;
		logic take_lock;
		logic pick_step;
		logic run;
		logic wait_calc;
		logic fix;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic op;
		logic slot_empty;
		logic adm_done;
		logic lock_hit;
		logic mode_none;
		logic out_free;
	} dp_stat_t;

endpackage

>>> hdl/tcjs_ctrl.sv
// ----------------------------------------------------------------------------
// tcjs_ctrl
// Sequencer: walks add, admission, selection and run steps of one beat.
// ----------------------------------------------------------------------------
module tcjs_ctrl #(
	parameter int MAX_JOBS = tcjs_pkg::MAX_JOBS_DEF,
	parameter int CNT_W    = $clog2(MAX_JOBS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  tcjs_pkg::dp_stat_t   stat,
	output tcjs_pkg::dp_cmd_t    cmd,
	output logic [CNT_W-1:0]     idx,
	output logic                 idle
);
	import tcjs_pkg::*;

	ctrl_st_t state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic last_slot;

	assign last_slot = (idx_q == CNT_W'(MAX_JOBS - 1));
	assign idx  = idx_q;
	assign idle = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				idx_d   = '0;
				state_d = (stat.op == OP_ADD) ? ST_ADD_SCAN : ST_ADMIT;
			end
			ST_ADD_SCAN: begin
				if (stat.slot_empty || last_slot) state_d = ST_OUT;
				else idx_d = idx_q + 1'b1;
			end
			ST_ADMIT: begin
				if (stat.adm_done) begin
					state_d = ST_PICK_INIT;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_PICK_INIT: begin
				idx_d = '0;
				if (stat.lock_hit || stat.mode_none) state_d = ST_RUN;
				else state_d = ST_PICK_SCAN;
			end
			ST_PICK_SCAN: begin
				if (last_slot) state_d = ST_RUN;
				else idx_d = idx_q + 1'b1;
			end
			ST_RUN:       state_d = ST_WAIT_CALC;
			ST_WAIT_CALC: state_d = ST_FIX;
			ST_FIX:       state_d = ST_OUT;
			ST_OUT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.latch = in_valid;
			ST_ADD_SCAN: begin
				cmd.add_step = stat.slot_empty;
				cmd.set_full = !stat.slot_empty && last_slot;
			end
			ST_ADMIT: begin
				cmd.adm_step = !stat.adm_done;
				cmd.adm_end  = stat.adm_done;
			end
			ST_PICK_INIT: begin
				cmd.pick_clear = 1'b1;
				cmd.take_lock  = stat.lock_hit;
			end
			ST_PICK_SCAN: cmd.pick_step = 1'b1;
			ST_RUN:       cmd.run = 1'b1;
			ST_WAIT_CALC: cmd.wait_calc = 1'b1;
			ST_FIX:       cmd.fix = 1'b1;
			ST_OUT:       cmd.out_load = stat.out_free;
			default:      cmd = '0;
		endcase
	end

endmodule

>>> hdl/tcjs_datapath.sv
// ----------------------------------------------------------------------------
// tcjs_datapath
// Job table, ready ordering, selection compare, timing sums, output register.
// ----------------------------------------------------------------------------
module tcjs_datapath #(
	parameter int MAX_JOBS  = tcjs_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = tcjs_pkg::TIME_BITS_DEF,
	parameter int CNT_W     = $clog2(MAX_JOBS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcjs_pkg::dp_cmd_t             cmd,
	input  logic [CNT_W-1:0]              idx,
	output tcjs_pkg::dp_stat_t            stat,
	input  logic                          cfg_write,
	input  logic [tcjs_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [tcjs_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          operation,
	input  logic [tcjs_pkg::ID_W-1:0]     job_id,
	input  logic [tcjs_pkg::BURST_W-1:0]  job_burst,
	input  logic [tcjs_pkg::PRIO_W-1:0]   job_priority,
	input  logic [tcjs_pkg::ARR_W-1:0]    job_arrival,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic                          table_full,
	output logic                          running_valid,
	output logic [tcjs_pkg::ID_W-1:0]     running_id,
	output logic                          job_finished,
	output logic [tcjs_pkg::TICK_W-1:0]   turnaround_ticks,
	output logic [tcjs_pkg::TICK_W-1:0]   waiting_ticks,
	output logic [tcjs_pkg::SUM_W-1:0]    sum_turnaround,
	output logic [tcjs_pkg::SUM_W-1:0]    sum_waiting,
	output logic [tcjs_pkg::DONE_W-1:0]   done_count,
	output logic [tcjs_pkg::TICK_W-1:0]   now_tick
);
	import tcjs_pkg::*;

	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

	// configuration
	logic [MODE_W-1:0]  mode_q;
	logic [QUANT_W-1:0] quant_q;

	// job table
	slot_st_t            status_q [MAX_JOBS];
	logic [ID_W-1:0]     ident_q  [MAX_JOBS];
	logic [BURST_W-1:0]  remain_q [MAX_JOBS];
	logic [BURST_W-1:0]  orig_q   [MAX_JOBS];
	logic [PRIO_W-1:0]   urg_q    [MAX_JOBS];
	logic [TIME_BITS-1:0] arr_q   [MAX_JOBS];
	logic [IDX_W-1:0]    order_q  [MAX_JOBS];
	logic [IDX_W-1:0]    waitq_q  [MAX_JOBS];

	logic [CNT_W-1:0]    oc_q, wcnt_q, kept_q;
	logic [TIME_BITS-1:0] time_q;
	logic [QUANT_W-1:0]  ql_q;
	logic [IDX_W-1:0]    lock_slot_q;
	logic                lock_valid_q;
	logic [SUM_W-1:0]    tot_turn_q, tot_wait_q;
	logic [DONE_W-1:0]   fin_cnt_q;

	// per beat working registers
	logic                op_q;
	logic [ID_W-1:0]     in_id_q;
	logic [BURST_W-1:0]  in_burst_q;
	logic [PRIO_W-1:0]   in_prio_q;
	logic [TIME_BITS-1:0] in_arr_q;
	logic [IDX_W-1:0]    best_q;
	logic [BURST_W-1:0]  bkey_q;
	logic [IDX_W-1:0]    bord_q;
	logic                bv_q;
	logic                rm_q, rot_q;
	logic                full_q, rv_q, fin_q;
	logic [ID_W-1:0]     rid_q;
	logic [TICK_W-1:0]   tat_q, wt_q, now_q;

	// output register
	logic                ov_q;

	// selection and read pointer
	logic [IDX_W-1:0]    slot_i, rank_i, wslot, rp;
	logic [BURST_W-1:0]  key_i;
	logic                better;
	logic                arrived;
	logic                done;
	logic [TIME_BITS-1:0] t_raw;
	logic [TICK_W-1:0]   tat_sat;
	logic [QUANT_W-1:0]  qv, ql0, ql_dec;
	logic                key_mode_burst, key_mode_prio, np_mode;

	assign slot_i = idx[IDX_W-1:0];
	assign rank_i = idx[IDX_W-1:0];
	assign wslot  = waitq_q[rank_i];
	assign rp     = cmd.adm_step ? wslot : (cmd.pick_step ? slot_i : best_q);

	assign key_mode_burst = (mode_q == MODE_SJF_NP) || (mode_q == MODE_SJF_P);
	assign key_mode_prio  = (mode_q == MODE_PRIO_NP) || (mode_q == MODE_PRIO_P);
	assign np_mode        = (mode_q == MODE_SJF_NP) || (mode_q == MODE_PRIO_NP);

	assign key_i = key_mode_burst ? remain_q[rp] :
	               key_mode_prio  ? BURST_W'(urg_q[rp]) : '0;
	assign better = (status_q[rp] == SLOT_READY) &&
	                (!bv_q || (key_i < bkey_q) || (key_i == bkey_q && order_q[rp] < bord_q));
	assign arrived = (arr_q[rp] <= time_q);
	assign done    = (remain_q[rp] <= BURST_W'(1));
	assign t_raw   = time_q + TIME_BITS'(1) - arr_q[rp];
	assign tat_sat = (64'(t_raw) > 64'hFFFF_FFFF) ? '1 : TICK_W'(t_raw);

	assign qv     = (quant_q == '0) ? QUANT_W'(1) : quant_q;
	assign ql0    = (ql_q == '0) ? qv : ql_q;
	assign ql_dec = ql0 - 1'b1;

	assign stat.op         = op_q;
	assign stat.slot_empty = (status_q[slot_i] == SLOT_EMPTY);
	assign stat.adm_done   = (idx >= wcnt_q);
	assign stat.lock_hit   = np_mode && lock_valid_q && (status_q[lock_slot_q] == SLOT_READY);
	assign stat.mode_none  = (mode_q > MODE_RR);
	assign stat.out_free   = !ov_q || !out_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FCFS;
			quant_q <= QUANT_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MODE:    mode_q  <= cfg_data[MODE_W-1:0];
				CFG_QUANTUM: quant_q <= cfg_data[QUANT_W-1:0];
				default:     mode_q  <= mode_q;
			endcase
		end
	end

	// slot status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOBS; i++) status_q[i] <= SLOT_EMPTY;
		end else begin
			if (cmd.add_step) status_q[slot_i] <= SLOT_WAIT;
			if (cmd.adm_step && arrived) status_q[wslot] <= SLOT_READY;
			if (cmd.fix && rm_q) status_q[best_q] <= SLOT_EMPTY;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (cmd.add_step) begin
			ident_q[slot_i]  <= in_id_q;
			remain_q[slot_i] <= (in_burst_q == '0) ? BURST_W'(1) : in_burst_q;
			orig_q[slot_i]   <= (in_burst_q == '0) ? BURST_W'(1) : in_burst_q;
			urg_q[slot_i]    <= in_prio_q;
			arr_q[slot_i]    <= in_arr_q;
			waitq_q[wcnt_q[IDX_W-1:0]] <= slot_i;
		end
		if (cmd.adm_step && !arrived) waitq_q[kept_q[IDX_W-1:0]] <= wslot;
		if (cmd.run && bv_q && !done) remain_q[best_q] <= remain_q[best_q] - 1'b1;
	end

	// ready order ranks, one lane per slot
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_JOBS; i++) begin
			if (cmd.adm_step && arrived && wslot == IDX_W'(i)) begin
				order_q[i] <= oc_q[IDX_W-1:0];
			end else if (cmd.fix && (rm_q || rot_q)) begin
				if (rot_q && best_q == IDX_W'(i))
					order_q[i] <= IDX_W'(oc_q - 1'b1);
				else if (status_q[i] == SLOT_READY && best_q != IDX_W'(i) &&
				         order_q[i] > order_q[best_q])
					order_q[i] <= order_q[i] - 1'b1;
			end
		end
	end

	// scheduler control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q         <= '0;
			wcnt_q       <= '0;
			kept_q       <= '0;
			time_q       <= '0;
			ql_q         <= '0;
			lock_slot_q  <= '0;
			lock_valid_q <= 1'b0;
			tot_turn_q   <= '0;
			tot_wait_q   <= '0;
			fin_cnt_q    <= '0;
			bv_q         <= 1'b0;
			rm_q         <= 1'b0;
			rot_q        <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			if (cmd.latch) begin
				kept_q <= '0;
				bv_q   <= 1'b0;
				rm_q   <= 1'b0;
				rot_q  <= 1'b0;
			end
			if (cmd.add_step) wcnt_q <= wcnt_q + 1'b1;
			if (cmd.adm_step) begin
				if (arrived) oc_q <= oc_q + 1'b1;
				else kept_q <= kept_q + 1'b1;
			end
			if (cmd.adm_end) wcnt_q <= kept_q;
			if (cmd.pick_clear) begin
				bv_q <= cmd.take_lock;
				if (cmd.take_lock) best_q <= lock_slot_q;
			end
			if (cmd.pick_step && better) begin
				bv_q   <= 1'b1;
				best_q <= slot_i;
				bkey_q <= key_i;
				bord_q <= order_q[rp];
			end
			if (cmd.run) begin
				if (np_mode) begin
					lock_valid_q <= bv_q && !done;
					lock_slot_q  <= bv_q ? best_q : '0;
				end else if (mode_q <= MODE_RR) begin
					lock_valid_q <= 1'b0;
				end
				rm_q <= bv_q && done;
				if (bv_q && mode_q == MODE_RR) begin
					if (done) begin
						ql_q <= qv;
					end else if (ql_dec == '0) begin
						ql_q  <= qv;
						rot_q <= 1'b1;
					end else begin
						ql_q <= ql_dec;
					end
				end
			end
			if (cmd.fix) begin
				time_q <= time_q + 1'b1;
				if (fin_q) begin
					tot_turn_q <= tot_turn_q + SUM_W'(tat_q);
					tot_wait_q <= tot_wait_q + SUM_W'(wt_q);
					fin_cnt_q  <= fin_cnt_q + 1'b1;
				end
				if (rm_q) oc_q <= oc_q - 1'b1;
			end
			if (cmd.out_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	// per beat results
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q       <= operation;
			in_id_q    <= job_id;
			in_burst_q <= job_burst;
			in_prio_q  <= job_priority;
			in_arr_q   <= TIME_BITS'(job_arrival);
			full_q     <= 1'b0;
			rv_q       <= 1'b0;
			fin_q      <= 1'b0;
			rid_q      <= '0;
			tat_q      <= '0;
			wt_q       <= '0;
			now_q      <= TICK_W'(64'(time_q));
		end
		if (cmd.set_full) full_q <= 1'b1;
		if (cmd.run && bv_q) begin
			rv_q  <= 1'b1;
			rid_q <= ident_q[best_q];
			fin_q <= done;
			if (done) tat_q <= tat_sat;
		end
		if (cmd.wait_calc && fin_q) begin
			wt_q <= (tat_q > TICK_W'(orig_q[best_q])) ? tat_q - TICK_W'(orig_q[best_q]) : '0;
		end
		if (cmd.out_load) begin
			table_full       <= full_q;
			running_valid    <= rv_q;
			running_id       <= rid_q;
			job_finished     <= fin_q;
			turnaround_ticks <= tat_q;
			waiting_ticks    <= wt_q;
			sum_turnaround   <= tot_turn_q;
			sum_waiting      <= tot_wait_q;
			done_count       <= fin_cnt_q;
			now_tick         <= now_q;
		end
	end

	assign out_valid = ov_q;

endmodule

>>> hdl/tick_cpu_job_scheduler.sv
// ----------------------------------------------------------------------------
// tick_cpu_job_scheduler
// Job table scheduler: add-job beats fill slots, tick beats admit, pick, run.
// ----------------------------------------------------------------------------
// add beat: the free slot search walks the table, one slot a cycle, then the result
//   is queued; tick beat: admission walks the waiting list, then, unless a held
//   non-preemptive job or an unused mode skips it, the selection scans every slot
// throughput: one beat at a time; next beat taken the cycle after the result is queued
// reset: all slots empty, time, totals, lock cleared, quantum one, no clearing pass
module tick_cpu_job_scheduler #(
	parameter int MAX_JOBS  = tcjs_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = tcjs_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_write,
	input  logic [tcjs_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [tcjs_pkg::CFG_W-1:0]    cfg_data,
	// input beat
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [tcjs_pkg::ID_W-1:0]     job_id,
	input  logic [tcjs_pkg::BURST_W-1:0]  job_burst,
	input  logic [tcjs_pkg::PRIO_W-1:0]   job_priority,
	input  logic [tcjs_pkg::ARR_W-1:0]    job_arrival,
	// result beat
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          table_full,
	output logic                          running_valid,
	output logic [tcjs_pkg::ID_W-1:0]     running_id,
	output logic                          job_finished,
	output logic [tcjs_pkg::TICK_W-1:0]   turnaround_ticks,
	output logic [tcjs_pkg::TICK_W-1:0]   waiting_ticks,
	output logic [tcjs_pkg::SUM_W-1:0]    sum_turnaround,
	output logic [tcjs_pkg::SUM_W-1:0]    sum_waiting,
	output logic [tcjs_pkg::DONE_W-1:0]   done_count,
	output logic [tcjs_pkg::TICK_W-1:0]   now_tick
);
	import tcjs_pkg::*;

	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	// command and status between sequencer and datapath
	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [CNT_W-1:0] idx;
	logic             idle;

	// a beat is only taken while the sequencer sits idle; the output register
	// lets the next beat enter while the last result still waits downstream
	assign in_stall = !idle;

	tcjs_ctrl #(
		.MAX_JOBS (MAX_JOBS),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.idx      (idx),
		.idle     (idle)
	);

	tcjs_datapath #(
		.MAX_JOBS  (MAX_JOBS),
		.TIME_BITS (TIME_BITS),
		.CNT_W     (CNT_W)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.idx              (idx),
		.stat             (stat),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.operation        (operation),
		.job_id           (job_id),
		.job_burst        (job_burst),
		.job_priority     (job_priority),
		.job_arrival      (job_arrival),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.table_full       (table_full),
		.running_valid    (running_valid),
		.running_id       (running_id),
		.job_finished     (job_finished),
		.turnaround_ticks (turnaround_ticks),
		.waiting_ticks    (waiting_ticks),
		.sum_turnaround   (sum_turnaround),
		.sum_waiting      (sum_waiting),
		.done_count       (done_count),
		.now_tick         (now_tick)
	);

`ifndef SYNTHESIS
	// an accepted beat keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a beat");

	// a finished job is always the running one
	a_fin_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && job_finished) |-> running_valid)
		else $error("finished flag without running job");

	// a full table only comes from an add beat, which runs nothing
	a_full_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> !running_valid)
		else $error("table full reported with a running job");

	// a new result is never loaded over one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load) |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");
`endif

endmodule

>>> tb/tick_cpu_job_scheduler_test.sv
// ----------------------------------------------------------------------------
// tick_cpu_job_scheduler_test
// Self-checking bench for the job scheduler: queued add and tick beats, a
// local model of the job table predicting every result beat, random stalls.
// ----------------------------------------------------------------------------
module tick_cpu_job_scheduler_test;
	import tcjs_pkg::*;

	localparam int NSLOT = MAX_JOBS_DEF;

	typedef struct {
		logic                op;
		logic [ID_W-1:0]     id;
		logic [BURST_W-1:0]  burst;
		logic [PRIO_W-1:0]   prio;
		logic [ARR_W-1:0]    arrival;
	} job_beat_t;

	typedef struct packed {
		logic                full;
		logic                run_v;
		logic [ID_W-1:0]     run_id;
		logic                fin;
		logic [TICK_W-1:0]   tat;
		logic [TICK_W-1:0]   wt;
		logic [SUM_W-1:0]    sum_t;
		logic [SUM_W-1:0]    sum_w;
		logic [DONE_W-1:0]   done;
		logic [TICK_W-1:0]   now;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	job_beat_t cur = '{OP_TICK, '0, '0, '0, '0};
	sched_res_t got;

	tick_cpu_job_scheduler i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(cur.op), .job_id(cur.id), .job_burst(cur.burst),
		.job_priority(cur.prio), .job_arrival(cur.arrival),
		.out_valid(out_valid), .out_stall(out_stall),
		.table_full(got.full), .running_valid(got.run_v), .running_id(got.run_id),
		.job_finished(got.fin), .turnaround_ticks(got.tat), .waiting_ticks(got.wt),
		.sum_turnaround(got.sum_t), .sum_waiting(got.sum_w),
		.done_count(got.done), .now_tick(got.now)
	);

	// 12 unit period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// job table mirror
	slot_st_t          tbl_st[NSLOT];
	logic [ID_W-1:0]   tbl_id[NSLOT];
	int unsigned       tbl_rem[NSLOT];
	int unsigned       tbl_orig[NSLOT];
	int unsigned       tbl_urg[NSLOT];
	logic [TICK_W-1:0] tbl_arr[NSLOT];
	int unsigned       tbl_rank[NSLOT];
	int unsigned       ready_cnt = 0;
	logic [TICK_W-1:0] sim_tick = '0;
	int unsigned       slice_left = 0;
	int unsigned       lock_slot = 0;
	bit                lock_on = 0;
	logic [SUM_W-1:0]  turn_total = '0;
	logic [SUM_W-1:0]  wait_total = '0;
	logic [DONE_W-1:0] fin_total = '0;
	logic [MODE_W-1:0] pol = MODE_FCFS;
	logic [QUANT_W-1:0] slice_cfg = 16'd1;

	job_beat_t  pend_q[$];
	sched_res_t exp_results[$];
	int  send_idle = 0;
	int  recv_idle = 0;
	bit  in_took = 0;
	bit  failed = 0;
	logic [TICK_W-1:0] gen_ticks = '0;

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			tbl_st[i] = SLOT_EMPTY;
			tbl_rank[i] = 0;
		end
	end

	// waiting jobs whose arrival has come join the ready order, oldest add first
	task automatic admit_jobs();
		int byrank[NSLOT];
		int s;
		int unsigned kept;
		kept = 0;
		for (int i = 0; i < NSLOT; i++) byrank[i] = -1;
		for (int i = 0; i < NSLOT; i++)
			if (tbl_st[i] == SLOT_WAIT && tbl_rank[i] < NSLOT) byrank[tbl_rank[i]] = i;
		for (int r = 0; r < NSLOT; r++) begin
			s = byrank[r];
			if (s < 0) continue;
			if (tbl_arr[s] <= sim_tick) begin
				tbl_st[s] = SLOT_READY;
				tbl_rank[s] = ready_cnt;
				ready_cnt++;
			end else begin
				tbl_rank[s] = kept;
				kept++;
			end
		end
	endtask

	function automatic int choose_job(logic [MODE_W-1:0] m);
		int best;
		int unsigned bk, bo, k;
		best = -1;
		bk = 0;
		bo = 0;
		for (int i = 0; i < NSLOT; i++) begin
			if (tbl_st[i] != SLOT_READY) continue;
			if (m == MODE_SJF_NP || m == MODE_SJF_P) k = tbl_rem[i];
			else if (m == MODE_PRIO_NP || m == MODE_PRIO_P) k = tbl_urg[i];
			else k = 0;
			// ties go to the job earlier in the ready order
			if (best < 0 || k < bk || (k == bk && tbl_rank[i] < bo)) begin
				best = i;
				bk = k;
				bo = tbl_rank[i];
			end
		end
		return best;
	endfunction

	task automatic sched_predict(input job_beat_t b, output sched_res_t r);
		int s, sel;
		int unsigned nwait, bl, q, o;
		bit done;
		logic [TICK_W-1:0] t;
		r = '{1'b0, 1'b0, '0, 1'b0, '0, '0, '0, '0, '0, sim_tick};
		if (b.op == OP_ADD) begin
			s = -1;
			nwait = 0;
			for (int i = NSLOT - 1; i >= 0; i--) if (tbl_st[i] == SLOT_EMPTY) s = i;
			for (int i = 0; i < NSLOT; i++) if (tbl_st[i] == SLOT_WAIT) nwait++;
			if (s < 0) begin
				r.full = 1'b1;
			end else begin
				// zero burst is stored as one tick
				bl = (b.burst == 0) ? 1 : b.burst;
				tbl_st[s] = SLOT_WAIT;
				tbl_id[s] = b.id;
				tbl_rem[s] = bl;
				tbl_orig[s] = bl;
				tbl_urg[s] = b.prio;
				tbl_arr[s] = b.arrival;
				tbl_rank[s] = nwait;
			end
		end else begin
			sel = -1;
			admit_jobs();
			if (pol <= MODE_RR) begin
				if (pol == MODE_SJF_NP || pol == MODE_PRIO_NP) begin
					if (lock_on && tbl_st[lock_slot] == SLOT_READY) begin
						sel = lock_slot;
					end else begin
						sel = choose_job(pol);
						lock_on = (sel >= 0);
						lock_slot = (sel >= 0) ? sel : 0;
					end
				end else begin
					lock_on = 0;
					sel = choose_job(pol);
				end
			end
			if (sel >= 0) begin
				q = (slice_cfg == 0) ? 1 : slice_cfg;
				if (pol == MODE_RR && slice_left == 0) slice_left = q;
				r.run_v = 1'b1;
				r.run_id = tbl_id[sel];
				done = (tbl_rem[sel] <= 1);
				if (!done) tbl_rem[sel]--;
				if (done) begin
					t = sim_tick + 1 - tbl_arr[sel];
					r.tat = t;
					r.wt = (t > tbl_orig[sel]) ? t - tbl_orig[sel] : '0;
					r.fin = 1'b1;
					turn_total += r.tat;
					wait_total += r.wt;
					fin_total++;
					// drop from the ready order and close the gap
					o = tbl_rank[sel];
					tbl_st[sel] = SLOT_EMPTY;
					for (int i = 0; i < NSLOT; i++)
						if (tbl_st[i] == SLOT_READY && tbl_rank[i] > o) tbl_rank[i]--;
					if (ready_cnt > 0) ready_cnt--;
					if (lock_on && lock_slot == sel) lock_on = 0;
				end
				if (pol == MODE_RR) begin
					slice_left--;
					if (done) begin
						slice_left = q;
					end else if (slice_left == 0) begin
						// slice expired: job goes to the tail
						o = tbl_rank[sel];
						for (int i = 0; i < NSLOT; i++)
							if (i != sel && tbl_st[i] == SLOT_READY && tbl_rank[i] > o)
								tbl_rank[i]--;
						tbl_rank[sel] = (ready_cnt > 0) ? ready_cnt - 1 : 0;
						slice_left = q;
					end
				end
			end
			sim_tick++;
		end
		r.sum_t = turn_total;
		r.sum_w = wait_total;
		r.done = fin_total;
	endtask

	// sample at the rising edge: config writes, accepted beats, result beats
	always @(posedge clk) begin
		sched_res_t want;
		if (arst_n) begin
			if (cfg_write) begin
				if (cfg_index == CFG_MODE) pol = cfg_data[MODE_W-1:0];
				else slice_cfg = cfg_data[QUANT_W-1:0];
			end
			if (in_valid && !in_stall) begin
				sched_predict(cur, want);
				exp_results.push_back(want);
				in_took = 1;
			end
			if (out_valid && !out_stall) begin
				if (exp_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %p", $time, got);
					failed = 1;
				end else begin
					want = exp_results.pop_front();
					if (got !== want) begin
						$display("%0t: expected %p", $time, want);
						$display("%0t: actual   %p", $time, got);
						failed = 1;
					end
				end
			end
		end
	end

	// drive at the falling edge: next beat once the current one is gone
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					cur <= pend_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			in_took = 0;
			out_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	task automatic queue_job(input logic op, input logic [ID_W-1:0] id,
			input logic [BURST_W-1:0] bl, input logic [PRIO_W-1:0] pr,
			input logic [ARR_W-1:0] ar);
		pend_q.push_back('{op, id, bl, pr, ar});
		if (op == OP_TICK) gen_ticks++;
	endtask

	task automatic queue_random();
		int r;
		logic [BURST_W-1:0] bl;
		logic [ARR_W-1:0] ar;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			bl = ($urandom_range(0, 19) == 0) ? '0 : BURST_W'($urandom_range(1, 8));
			if ($urandom_range(0, 9) == 0) ar = gen_ticks - $urandom_range(0, 5);
			else ar = gen_ticks + $urandom_range(0, 12);
			queue_job(OP_ADD, ID_W'($urandom), bl, PRIO_W'($urandom), ar);
		end else begin
			// tick beats carry junk in the unused fields
			queue_job(OP_TICK, ID_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom),
				ARR_W'($urandom));
		end
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		while (pend_q.size() > 0 || exp_results.size() > 0 || in_valid) @(negedge clk);
		// result beats all in, let the block settle before touching registers
		repeat (2 * NSLOT + 8) @(negedge clk);
	endtask

	initial begin
		logic [MODE_W-1:0] modes[8];
		logic [QUANT_W-1:0] slices[8];
		modes = '{MODE_FCFS, MODE_RR, MODE_SJF_NP, MODE_SJF_P, MODE_PRIO_NP,
			MODE_PRIO_P, 3'd6, MODE_RR};
		slices = '{16'd1, 16'd3, 16'd2, 16'd0, 16'd5, 16'd1, 16'd4, 16'hFFFF};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, zero burst, a job that never arrives, full table
		queue_job(OP_ADD, 8'd0, 16'd1, 8'd0, 32'd0);
		queue_job(OP_ADD, 8'hFF, 16'd0, 8'hFF, 32'd0);
		queue_job(OP_ADD, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 14; i++) queue_job(OP_ADD, 8'(i + 1), 16'd2, 8'(i), 32'd1);
		for (int i = 0; i < 6; i++) queue_job(OP_TICK, '0, '0, '0, '0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_MODE, CFG_W'(modes[ph]));
			write_reg(CFG_QUANTUM, slices[ph]);
			if (ph < 3) begin
				send_idle = 13;
				recv_idle = 53;
			end else if (ph < 6) begin
				send_idle = 53;
				recv_idle = 13;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int n = 0; n < 175; n++) begin
				queue_random();
				// sender holds off halfway until every result is back
				if (ph == 1 && n == 87) drain();
			end
			drain();
		end

		if (!failed) begin
			$display("tick_cpu_job_scheduler: match");
		end else begin
			$display("tick_cpu_job_scheduler: mismatch");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 1000000);
		$display("tick_cpu_job_scheduler: mismatch");
		$finish;
	end

endmodule
